/* sv/pmsc_pkg.sv */
// Package for the PI motor speed controller core: register indexes,
// reset values and fixed field widths. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package pmsc_pkg;
	localparam int ENCODER_BITS_DEF    = 32;
	localparam int TICK_COUNT_BITS_DEF = 10;

	localparam int CFG_INDEX_BITS = 3;
	localparam int CFG_DATA_BITS  = 16;
	localparam int SPEED_BITS     = 24;
	localparam int ERR_BITS       = 26;
	localparam int INTEG_BITS     = 32;
	localparam int GAIN_BITS      = 16;
	localparam int SUM_BITS       = 43;

	localparam logic [2:0] REG_PERIOD  = 3'd0;
	localparam logic [2:0] REG_GNOW    = 3'd1;
	localparam logic [2:0] REG_GPRIOR  = 3'd2;
	localparam logic [2:0] REG_DMAX    = 3'd3;
	localparam logic [2:0] REG_DMIN    = 3'd4;
	localparam logic [2:0] REG_DBAND   = 3'd5;
	localparam logic [2:0] REG_SCALE   = 3'd6;

	localparam logic [9:0]         RST_PERIOD = 10'd100;
	localparam logic signed [15:0] RST_GNOW   = 16'sd5378;
	localparam logic signed [15:0] RST_GPRIOR = -16'sd4862;
	localparam logic signed [7:0]  RST_DMAX   = 8'sd120;
	localparam logic signed [7:0]  RST_DMIN   = 8'sd0;
	localparam logic [6:0]         RST_DBAND  = 7'd20;
	localparam logic [15:0]        RST_SCALE  = 16'd2842;
endpackage
`default_nettype wire

/* sv/pi_motor_speed_controller_core.sv */
// PI motor speed controller core: speed measurement and incremental PI update.
// Depends on pmsc_pkg.
// A tick with no action goes straight to the result beat. A speed measurement runs a
// 16-step serial multiply and a restoring divide of ENCODER_BITS + 16 steps, then stores
// the speed; a PI update then runs a setup step, two 16-step serial multiplies and the
// finishing states that saturate the sum and set drive and integrator, before the beat.
// Flow: one tick at a time. The sequencer waits in its done state while the output is
// stalled and returns to idle, ready for the next tick, as the beat is registered.
// Reset: arst_n clears sequencer and PI state and loads the configuration reset values.
`timescale 1ns / 1ps
`default_nettype none
module pi_motor_speed_controller_core #(
	parameter int ENCODER_BITS    = pmsc_pkg::ENCODER_BITS_DEF,
	parameter int TICK_COUNT_BITS = pmsc_pkg::TICK_COUNT_BITS_DEF
) (
	input  wire                                  clk,
	input  wire                                  arst_n,
	input  wire                                  in_valid,
	output logic                                 in_stall,
	input  wire  [31:0]                          encoder_position,
	input  wire  [7:0]                           speed_setpoint,
	output logic                                 out_valid,
	input  wire                                  out_stall,
	output logic signed [7:0]                    drive_level,
	output logic [pmsc_pkg::SPEED_BITS-1:0]      measured_speed,
	output logic                                 speed_sampled,
	output logic                                 control_updated,
	input  wire                                  cfg_valid,
	output logic                                 cfg_ready,
	input  wire  [pmsc_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
	input  wire  [pmsc_pkg::CFG_DATA_BITS-1:0]   cfg_data
);
	import pmsc_pkg::*;

	localparam int EB   = ENCODER_BITS;
	localparam int TB   = TICK_COUNT_BITS;
	localparam int PW   = EB + 16;             // width of delta times scale
	localparam int CW   = $clog2(PW + 1);
	localparam int CMPW = 17;
	localparam logic [TB-1:0] TICK_MAX = {TB{1'b1}};

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_MUL  = 3'd1;
	localparam logic [2:0] S_DIV  = 3'd2;
	localparam logic [2:0] S_PSET = 3'd3;
	localparam logic [2:0] S_PMUL = 3'd4;
	localparam logic [2:0] S_PADD = 3'd5;
	localparam logic [2:0] S_POUT = 3'd6;
	localparam logic [2:0] S_DONE = 3'd7;

	// Configuration registers. Writes must be issued only while idle; the block itself
	// does not enforce this, and the port is always ready.
	logic [9:0]         period_q;
	logic signed [15:0] gnow_q, gprior_q;
	logic signed [7:0]  dmax_q, dmin_q;
	logic [6:0]         dband_q;
	logic [15:0]        scale_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q <= RST_PERIOD;
			gnow_q   <= RST_GNOW;
			gprior_q <= RST_GPRIOR;
			dmax_q   <= RST_DMAX;
			dmin_q   <= RST_DMIN;
			dband_q  <= RST_DBAND;
			scale_q  <= RST_SCALE;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_PERIOD: period_q <= cfg_data[9:0];
				REG_GNOW:   gnow_q   <= cfg_data;
				REG_GPRIOR: gprior_q <= cfg_data;
				REG_DMAX:   dmax_q   <= cfg_data[7:0];
				REG_DMIN:   dmin_q   <= cfg_data[7:0];
				REG_DBAND:  dband_q  <= cfg_data[6:0];
				REG_SCALE:  scale_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// Sequencer state and working registers.
	logic [2:0]    state_q;
	logic [TB-1:0] mt_q, ct_q;
	logic [EB-1:0] prev_enc_q;
	logic [SPEED_BITS-1:0] speed_q;
	logic signed [ERR_BITS-1:0]   perr_q, err_q;
	logic signed [INTEG_BITS-1:0] integ_q, anew_q;
	logic signed [7:0] drive_q;
	logic [7:0]    sp_q;
	logic          samp_q, upd_q;
	logic [CW-1:0] cnt_q;

	// Serial multiplier (delta times scale), then restoring divider that
	// reuses the product register for the quotient.
	logic [EB-1:0] mag_q;
	logic [EB-1:0] mhi_q;
	logic [15:0]   mlo_q;
	logic [PW-1:0] quo_q;
	logic [TB-1:0] rem_q, elapsed_q;

	// Serial signed multiply-accumulate for the PI sum.
	logic signed [SUM_BITS-1:0] mcand_q, acc_q;
	logic [GAIN_BITS-1:0]       gain_q;

	// Output register.
	logic out_valid_q;
	logic out_free;
	logic done_fire;
	assign out_free  = !out_valid_q || !out_stall;
	assign out_valid = out_valid_q;
	// The finished tick hands its beat over once the speed is stored.
	assign done_fire = (state_q == S_DONE) && out_free && !(samp_q && !upd_q && cnt_q != '0);

	assign in_stall = (state_q != S_IDLE);
	logic in_acc;
	assign in_acc = in_valid && !in_stall;

	// Counters advance on every tick, saturate at their ceiling and restart from zero when due.
	logic [TB-1:0] mt_next, ct_next;
	logic          m_due, c_due;
	logic [EB-1:0] enc_in, delta;
	assign enc_in  = encoder_position[EB-1:0];
	assign mt_next = (mt_q < TICK_MAX) ? mt_q + 1'b1 : mt_q;
	assign ct_next = (ct_q < TICK_MAX) ? ct_q + 1'b1 : ct_q;
	assign m_due   = CMPW'(mt_next) >= CMPW'(period_q >> 1);
	assign c_due   = CMPW'(ct_next) >= CMPW'(period_q);
	assign delta   = enc_in - prev_enc_q;

	// Datapath helpers.
	logic [EB:0]   msum;
	logic [TB:0]   rshift;
	logic          rfit;
	logic signed [SUM_BITS-1:0] addend, tround, incr;
	logic signed [33:0] isum;
	logic signed [ERR_BITS-1:0] err_calc;
	logic signed [INTEG_BITS-1:0] hi_lim, lo_lim, db_lim, a_abs;
	logic signed [7:0] drive_calc;

	assign msum   = {1'b0, mhi_q} + (mlo_q[0] ? {1'b0, mag_q} : '0);
	assign rshift = {rem_q, quo_q[PW-1]};
	assign rfit   = rshift >= {1'b0, elapsed_q};

	assign err_calc = $signed({2'b00, sp_q, 8'h00}) - $signed({2'b00, speed_q});
	// The last gain bit carries negative weight.
	assign addend = !gain_q[0] ? '0 :
		(cnt_q[3:0] == 4'd15) ? -mcand_q : mcand_q;

	// Round to nearest, ties up, then floor-shift by the gain fraction.
	assign tround = acc_q + SUM_BITS'(2048);
	assign incr   = tround >>> 12;
	assign isum   = {{2{integ_q[31]}}, integ_q} + incr[33:0];

	assign hi_lim = {{16{dmax_q[7]}}, dmax_q, 8'h00};
	assign lo_lim = {{16{dmin_q[7]}}, dmin_q, 8'h00};
	assign db_lim = {17'd0, dband_q, 8'h00};
	assign a_abs  = anew_q[31] ? -anew_q : anew_q;

	always_comb begin
		priority if (anew_q > hi_lim) begin
			drive_calc = dmax_q;
		end else if (anew_q < lo_lim) begin
			drive_calc = dmin_q;
		end else if (anew_q < db_lim && anew_q > -db_lim) begin
			drive_calc = '0;
		end else begin
			drive_calc = anew_q[31] ? -$signed(a_abs[15:8]) : $signed(a_abs[15:8]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			mt_q        <= '0;
			ct_q        <= '0;
			prev_enc_q  <= '0;
			speed_q     <= '0;
			perr_q      <= '0;
			integ_q     <= '0;
			drive_q     <= '0;
			out_valid_q <= 1'b0;
			samp_q      <= 1'b0;
			upd_q       <= 1'b0;
			cnt_q       <= '0;
		end else begin
			out_valid_q <= done_fire || (out_valid_q && out_stall);
			unique case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						sp_q      <= speed_setpoint;
						samp_q    <= m_due;
						upd_q     <= c_due;
						mt_q      <= m_due ? '0 : mt_next;
						ct_q      <= c_due ? '0 : ct_next;
						elapsed_q <= mt_next;
						mag_q     <= delta[EB-1] ? -delta : delta;
						mhi_q     <= '0;
						mlo_q     <= scale_q;
						cnt_q     <= '0;
						if (m_due) prev_enc_q <= enc_in;
						state_q   <= m_due ? S_MUL : (c_due ? S_PSET : S_DONE);
					end
				end
				S_MUL: begin
					mhi_q <= msum[EB:1];
					mlo_q <= {msum[0], mlo_q[15:1]};
					if (cnt_q == CW'(15)) begin
						quo_q   <= {msum[EB:1], msum[0], mlo_q[15:1]};
						rem_q   <= '0;
						cnt_q   <= '0;
						state_q <= S_DIV;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				S_DIV: begin
					rem_q <= rfit ? TB'(rshift - {1'b0, elapsed_q}) : rshift[TB-1:0];
					quo_q <= {quo_q[PW-2:0], rfit};
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CW'(PW - 1)) begin
						state_q <= upd_q ? S_PSET : S_DONE;
					end
				end
				S_PSET: begin
					if (samp_q && cnt_q != '0) begin
						// Quotient is complete: saturate it into the speed register.
						speed_q <= (|quo_q[PW-1:SPEED_BITS]) ? {SPEED_BITS{1'b1}}
							: quo_q[SPEED_BITS-1:0];
						cnt_q   <= '0;
					end else begin
						err_q   <= err_calc;
						mcand_q <= SUM_BITS'(err_calc);
						gain_q  <= gnow_q;
						acc_q   <= '0;
						cnt_q   <= '0;
						state_q <= S_PMUL;
					end
				end
				S_PMUL: begin
					acc_q <= acc_q + addend;
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CW'(15)) begin
						mcand_q <= SUM_BITS'(perr_q);
						gain_q  <= gprior_q;
					end else begin
						mcand_q <= mcand_q <<< 1;
						gain_q  <= gain_q >> 1;
					end
					if (cnt_q == CW'(31)) state_q <= S_PADD;
				end
				S_PADD: begin
					perr_q <= err_q;
					if (sp_q == '0) begin
						anew_q <= '0;
					end else if (isum[33:31] != 3'b000 && isum[33:31] != 3'b111) begin
						anew_q <= isum[33] ? {1'b1, 31'd0} : {1'b0, {31{1'b1}}};
					end else begin
						anew_q <= isum[31:0];
					end
					state_q <= S_POUT;
				end
				S_POUT: begin
					drive_q <= drive_calc;
					integ_q <= (anew_q < lo_lim) ? lo_lim : anew_q;
					state_q <= S_DONE;
				end
				S_DONE: begin
					// A measurement without update still has its speed to store.
					if (samp_q && !upd_q && cnt_q != '0) begin
						speed_q <= (|quo_q[PW-1:SPEED_BITS]) ? {SPEED_BITS{1'b1}}
							: quo_q[SPEED_BITS-1:0];
						cnt_q   <= '0;
					end else if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// The output beat carries the state as it stands after this tick.
	always_ff @(posedge clk) begin
		if (done_fire) begin
			drive_level     <= drive_q;
			measured_speed  <= speed_q;
			speed_sampled   <= samp_q;
			control_updated <= upd_q;
		end
	end

	a_busy_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_IDLE) |-> in_stall)
		else $error("input accepted while the sequencer is busy");
	a_div_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIV) |-> (elapsed_q != '0))
		else $error("speed divide with zero elapsed ticks");
	a_done_loads: assert property (@(posedge clk) disable iff (!arst_n)
		done_fire |=> (out_valid && state_q == S_IDLE))
		else $error("finished tick did not produce a result beat");
endmodule
`default_nettype wire
